>>> src/bpr_pkg.sv
// Shared types and constants of the byte pattern replace block.
package bpr_pkg;

    localparam int MAX_PATTERN_DEFAULT = 12;
    localparam int REG_BYTES           = 12;
    localparam int LEN_W               = 4;
    localparam int COUNT_W             = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 64;
    localparam int QUEUE_DEPTH         = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_REPLACE_LOW  = 3'd2,
        CFG_REPLACE_HIGH = 3'd3,
        CFG_PATTERN_LEN  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [REG_BYTES-1:0][7:0] pattern;
        logic [REG_BYTES-1:0][7:0] replace;
        logic [LEN_W-1:0]          length;
    } cfg_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               start;
        logic [7:0]         data;
    } result_t;

endpackage

>>> src/byte_pattern_replace_all.sv
// Input bytes are registered in the queue; released bytes go out from the engine's register.
// Throughput: one byte per cycle while the output is ready and no flush or drain step runs.
// At a record end the rest of the window is flushed, one byte a cycle while output is free.
// Reset (aresetn low, synchronous) empties the queue and window, clears the match count,
// sets the pattern and replacement to zero and the pattern length to one.
//
// Top level of the streaming find-and-replace block. The front queue takes input transfers
// and holds them so that the input keeps flowing while the window engine waits on the output.
// The window engine keeps the last pattern-length bytes of the record. Whenever the window is
// full it is compared with the pattern, with earlier replacements already applied; a hit
// overwrites the window with the replacement bytes, flags the oldest byte as a match start
// and counts the match. The oldest byte then goes out. The last byte of a record carries the
// saturating match count. If the pattern length was shortened between records' bytes, the
// engine first drains the surplus window bytes when the next byte is waiting in the queue.
module byte_pattern_replace_all #(
    parameter int MAX_PATTERN = bpr_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [7:0] out_byte, [19:8] match_count
    output logic [0:0]                     m_tuser,   // [0] match_start
    output logic                           m_tlast
);
    import bpr_pkg::*;

    cfg_t    cfg;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t m_res;

    bpr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    bpr_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    // Pack the result; the upper nibble of the data bus stays zero.
    assign m_tdata = {4'b0000, m_res.count, m_res.data};
    assign m_tuser = m_res.start;
    assign m_tlast = m_res.last;

endmodule

>>> src/bpr_cfg.sv
// Configuration register file: pattern, replacement and pattern length.
module bpr_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bpr_pkg::cfg_t                    cfg
);
    import bpr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PATTERN_LOW:  cfg_next.pattern[7:0]  = cfg_data;
                CFG_PATTERN_HIGH: cfg_next.pattern[11:8] = cfg_data[31:0];
                CFG_REPLACE_LOW:  cfg_next.replace[7:0]  = cfg_data;
                CFG_REPLACE_HIGH: cfg_next.replace[11:8] = cfg_data[31:0];
                CFG_PATTERN_LEN:  cfg_next.length        = cfg_data[LEN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern <= '0;
            cfg_reg.replace <= '0;
            cfg_reg.length  <= LEN_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/bpr_front.sv
// Input side: accepts byte transfers into a short queue toward the window engine.
module bpr_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    output logic            q_valid,
    output bpr_pkg::item_t  q_item,
    input  logic            q_pop
);
    import bpr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != '0);
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= '{last: s_tlast, data: s_tdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/bpr_back.sv
// Window engine: inserts bytes, compares and replaces, and emits the oldest byte.
module bpr_back #(
    parameter int MAX_PATTERN = bpr_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bpr_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  bpr_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output bpr_pkg::result_t  m_res
);
    import bpr_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    logic [7:0]        pat_b [MAX_PATTERN];
    logic [7:0]        rep_b [MAX_PATTERN];

    logic [7:0]        win_reg    [MAX_PATTERN];
    logic [7:0]        win_next   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] starts_reg, starts_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic              flush_reg, flush_next;
    logic              m_valid_reg, m_valid_next;
    result_t           res_reg, res_next;

    logic [FILL_W-1:0] len;
    logic [FILL_W-1:0] wfill;
    logic [7:0]        w_bytes [MAX_PATTERN];
    logic [7:0]        r_bytes [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_starts;
    logic              out_free, step, drain, consume;
    logic              cmp_path, hit, do_hit, eff_last, out_last, emit;
    logic [COUNT_W-1:0] cnt_inc;

    // Pattern and replacement bytes past the register file read as zero.
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_bytes
        if (g < REG_BYTES) begin : g_reg
            assign pat_b[g] = cfg.pattern[g];
            assign rep_b[g] = cfg.replace[g];
        end else begin : g_zero
            assign pat_b[g] = '0;
            assign rep_b[g] = '0;
        end
    end

    always_comb begin
        if (cfg.length == '0) begin
            len = FILL_W'(1);
        end else if (int'(cfg.length) > MAX_PATTERN) begin
            len = FILL_W'(MAX_PATTERN);
        end else begin
            len = FILL_W'(cfg.length);
        end
    end

    // One step a cycle if output is free: drain, flush, or take a byte.
    assign out_free = !m_valid_reg || m_ready;
    assign drain    = (fill_reg >= len);
    assign step     = out_free && (flush_reg || q_valid);
    assign consume  = step && !flush_reg && !drain;
    assign q_pop    = consume;
    assign wfill    = fill_reg + FILL_W'(consume);

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (consume && (FILL_W'(k) == fill_reg)) begin
                w_bytes[k]  = q_item.data;
                w_starts[k] = 1'b0;
            end else begin
                w_bytes[k]  = win_reg[k];
                w_starts[k] = starts_reg[k];
            end
        end
    end

    always_comb begin
        hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((FILL_W'(k) < len) && (w_bytes[k] != pat_b[k])) begin
                hit = 1'b0;
            end
        end
    end

    assign cmp_path = (wfill >= len);
    assign do_hit   = step && cmp_path && hit;
    assign eff_last = flush_reg || (consume && q_item.last);
    assign out_last = eff_last && (wfill == FILL_W'(1));
    assign emit     = step && (cmp_path || (eff_last && (wfill != '0)));
    assign cnt_inc  = (do_hit && (cnt_reg != COUNT_MAX)) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            r_bytes[k] = (do_hit && (FILL_W'(k) < len)) ? rep_b[k] : w_bytes[k];
        end
    end

    always_comb begin
        win_next    = w_bytes;
        starts_next = w_starts;
        fill_next   = wfill;
        cnt_next    = cnt_reg;
        flush_next  = flush_reg;
        if (emit) begin
            for (int k = 0; k < MAX_PATTERN - 1; k++) begin
                win_next[k]    = r_bytes[k + 1];
                starts_next[k] = w_starts[k + 1];
            end
            win_next[MAX_PATTERN-1]    = '0;
            starts_next[MAX_PATTERN-1] = 1'b0;
            fill_next = wfill - 1'b1;
            cnt_next  = cnt_inc;
        end
        if (consume && q_item.last) begin
            flush_next = 1'b1;
        end
        if (emit && out_last) begin
            starts_next = '0;
            fill_next   = '0;
            cnt_next    = '0;
            flush_next  = 1'b0;
        end
    end

    always_comb begin
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (emit) begin
            res_next.data  = r_bytes[0];
            res_next.start = w_starts[0] || do_hit;
            res_next.last  = out_last;
            res_next.count = out_last ? cnt_inc : '0;
            m_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            starts_reg  <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            starts_reg  <= starts_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

endmodule
